[rtl/core/mtf_pkg.sv]
`timescale 1ns / 1ps

package mtf_pkg;

    localparam int NEURONS    = 4;
    localparam int DIST_W     = 16;
    localparam int ANG_W      = 11;
    localparam int WGT_W      = 16;
    localparam int Q14_W      = 16;
    localparam int ARG_W      = 24;
    localparam int TAB_W      = 15;
    localparam int STEP_BITS  = 10;
    localparam int IDX_W      = 5;
    localparam int DELTA_W    = 13;
    localparam int TPROD_W    = DELTA_W + STEP_BITS;
    localparam int HPROD_D_W  = DIST_W + WGT_W;
    localparam int HPROD_A_W  = ANG_W + WGT_W;
    localparam int HACC_W     = 34;
    localparam int OPROD_W    = Q14_W + WGT_W;
    localparam int OACC_W     = 34;
    localparam int BIAS_SHIFT = 9;
    localparam int HID_SHIFT  = 9;
    localparam int OUT_SHIFT  = 14;
    localparam int TANH_LIMIT = 20480;
    localparam int TANH_ONE   = 16384;

    typedef logic signed [WGT_W-1:0]  t_wgt;
    typedef logic signed [ARG_W-1:0]  t_arg;
    typedef logic signed [Q14_W-1:0]  t_q14;
    typedef logic signed [HACC_W-1:0] t_hacc;
    typedef logic signed [OACC_W-1:0] t_oacc;
    typedef logic [TAB_W-1:0]         t_tab;

    typedef t_arg t_arg_vec [NEURONS];
    typedef t_q14 t_q14_vec [NEURONS];

    localparam t_wgt W_HID_BIAS [NEURONS] = '{16'sd7779, -16'sd1954, -16'sd2656, -16'sd1581};
    localparam t_wgt W_HID_DIST [NEURONS] = '{-16'sd1155, 16'sd16428, 16'sd13227, -16'sd11855};
    localparam t_wgt W_HID_ANG  [NEURONS] = '{16'sd1368, -16'sd5741, 16'sd5562, -16'sd4020};

    // Rows are hidden neurons, columns are output neurons.
    localparam t_wgt W_OUT [NEURONS][NEURONS] = '{
        '{16'sd4653, 16'sd6333, 16'sd6633, 16'sd7708},
        '{-16'sd6336, 16'sd5715, 16'sd794, 16'sd1269},
        '{-16'sd3177, 16'sd3846, 16'sd8545, -16'sd4600},
        '{-16'sd5061, 16'sd3516, 16'sd2968, 16'sd3999}
    };

    // tanh sampled at steps of 0.25 in Q1.14; the point at 5.0 and beyond is one.
    function automatic t_tab tanh_point(input logic [IDX_W-1:0] idx);
        t_tab v;
        case (idx)
            5'd0:    v = 15'd0;
            5'd1:    v = 15'd4013;
            5'd2:    v = 15'd7571;
            5'd3:    v = 15'd10406;
            5'd4:    v = 15'd12478;
            5'd5:    v = 15'd13898;
            5'd6:    v = 15'd14830;
            5'd7:    v = 15'd15423;
            5'd8:    v = 15'd15795;
            5'd9:    v = 15'd16024;
            5'd10:   v = 15'd16165;
            5'd11:   v = 15'd16251;
            5'd12:   v = 15'd16303;
            5'd13:   v = 15'd16335;
            5'd14:   v = 15'd16354;
            5'd15:   v = 15'd16366;
            5'd16:   v = 15'd16373;
            5'd17:   v = 15'd16377;
            5'd18:   v = 15'd16380;
            5'd19:   v = 15'd16382;
            default: v = 15'd16384;
        endcase
        return v;
    endfunction

    function automatic logic [DELTA_W-1:0] tanh_delta(input logic [IDX_W-1:0] idx);
        t_tab d;
        d = tanh_point(idx + 5'd1) - tanh_point(idx);
        return d[DELTA_W-1:0];
    endfunction

endpackage

[rtl/core/mtf_in_if.sv]
`timescale 1ns / 1ps

interface mtf_in_if import mtf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DIST_W-1:0] feature_dist;
    logic signed [ANG_W-1:0]  feature_angle;

    modport source (output valid, output feature_dist, output feature_angle, input ready);
    modport sink   (input valid, input feature_dist, input feature_angle, output ready);
endinterface

[rtl/core/mtf_out_if.sv]
`timescale 1ns / 1ps

interface mtf_out_if import mtf_pkg::*; ();
    logic valid;
    logic ready;
    t_q14 out_zero;
    t_q14 out_one;
    t_q14 out_two;
    t_q14 out_three;

    modport source (output valid, output out_zero, output out_one, output out_two,
                    output out_three, input ready);
    modport sink   (input valid, input out_zero, input out_one, input out_two,
                    input out_three, output ready);
endinterface

[rtl/core/mtf_hidden.sv]
`timescale 1ns / 1ps

module mtf_hidden import mtf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    output logic                     o_rdy,
    input  logic signed [DIST_W-1:0] i_dist,
    input  logic signed [ANG_W-1:0]  i_ang,
    output logic                     o_vld,
    input  logic                     i_rdy,
    output t_arg_vec                 o_x
);

    logic                        r_vld1, r_vld2;
    logic signed [HPROD_D_W-1:0] r_pd [NEURONS];
    logic signed [HPROD_A_W-1:0] r_pa [NEURONS];
    logic signed [HPROD_D_W-1:0] n_pd [NEURONS];
    logic signed [HPROD_A_W-1:0] n_pa [NEURONS];
    t_arg_vec                    r_x, n_x;
    t_hacc                       acc  [NEURONS];
    logic                        en1, en2;

    assign en2   = !r_vld2 || i_rdy;
    assign en1   = !r_vld1 || en2;
    assign o_rdy = en1;
    assign o_vld = r_vld2;
    assign o_x   = r_x;

    always_comb begin
        for (int j = 0; j < NEURONS; j++) begin
            n_pd[j] = i_dist * W_HID_DIST[j];
            n_pa[j] = i_ang * W_HID_ANG[j];
        end
    end

    // Bias is 1.0 in Q7.9, so its product is the weight shifted up.
    always_comb begin
        for (int j = 0; j < NEURONS; j++) begin
            acc[j] = t_hacc'(r_pd[j]) + t_hacc'(r_pa[j])
                   + (t_hacc'(W_HID_BIAS[j]) <<< BIAS_SHIFT)
                   + (t_hacc'(1) <<< (HID_SHIFT - 1));
            n_x[j] = t_arg'(acc[j] >>> HID_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) r_vld1 <= i_vld;
            if (en2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_vld) begin
            r_pd <= n_pd;
            r_pa <= n_pa;
        end
        if (en2 && r_vld1) begin
            r_x <= n_x;
        end
    end

endmodule

[rtl/core/mtf_output.sv]
`timescale 1ns / 1ps

module mtf_output import mtf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_vld,
    output logic     o_rdy,
    input  t_q14_vec i_hid,
    output logic     o_vld,
    input  logic     i_rdy,
    output t_arg_vec o_x
);

    logic                      r_vld1, r_vld2;
    logic signed [OPROD_W-1:0] r_p [NEURONS][NEURONS];
    logic signed [OPROD_W-1:0] n_p [NEURONS][NEURONS];
    t_arg_vec                  r_x, n_x;
    t_oacc                     acc [NEURONS];
    logic                      en1, en2;

    assign en2   = !r_vld2 || i_rdy;
    assign en1   = !r_vld1 || en2;
    assign o_rdy = en1;
    assign o_vld = r_vld2;
    assign o_x   = r_x;

    always_comb begin
        for (int j = 0; j < NEURONS; j++) begin
            for (int k = 0; k < NEURONS; k++) begin
                n_p[j][k] = i_hid[j] * W_OUT[j][k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NEURONS; k++) begin
            acc[k] = t_oacc'(1) <<< (OUT_SHIFT - 1);
            for (int j = 0; j < NEURONS; j++) begin
                acc[k] = acc[k] + t_oacc'(r_p[j][k]);
            end
            n_x[k] = t_arg'(acc[k] >>> OUT_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) r_vld1 <= i_vld;
            if (en2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_vld) begin
            r_p <= n_p;
        end
        if (en2 && r_vld1) begin
            r_x <= n_x;
        end
    end

endmodule

[rtl/core/mtf_tanh.sv]
`timescale 1ns / 1ps

module mtf_tanh import mtf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_vld,
    output logic     o_rdy,
    input  t_arg_vec i_x,
    output logic     o_vld,
    input  logic     i_rdy,
    output t_q14_vec o_y
);

    logic                     r_vld1, r_vld2;
    logic                     r_neg  [NEURONS];
    logic                     r_sat  [NEURONS];
    t_tab                     r_base [NEURONS];
    logic [TPROD_W-1:0]       r_prod [NEURONS];
    logic                     n_neg  [NEURONS];
    logic                     n_sat  [NEURONS];
    t_tab                     n_base [NEURONS];
    logic [TPROD_W-1:0]       n_prod [NEURONS];
    logic [ARG_W-1:0]         ax     [NEURONS];
    logic [IDX_W-1:0]         idx    [NEURONS];
    logic [TPROD_W-1:0]       rnd    [NEURONS];
    t_tab                     y      [NEURONS];
    t_q14_vec                 r_y, n_y;
    logic                     en1, en2;

    assign en2   = !r_vld2 || i_rdy;
    assign en1   = !r_vld1 || en2;
    assign o_rdy = en1;
    assign o_vld = r_vld2;
    assign o_y   = r_y;

    // First half: magnitude, segment lookup and slope times fraction.
    always_comb begin
        for (int j = 0; j < NEURONS; j++) begin
            n_neg[j]  = i_x[j][ARG_W-1];
            ax[j]     = n_neg[j] ? ARG_W'(-i_x[j]) : ARG_W'(i_x[j]);
            n_sat[j]  = ax[j] >= ARG_W'(TANH_LIMIT);
            idx[j]    = ax[j][STEP_BITS+IDX_W-1:STEP_BITS];
            n_base[j] = tanh_point(idx[j]);
            n_prod[j] = TPROD_W'(tanh_delta(idx[j])) * TPROD_W'(ax[j][STEP_BITS-1:0]);
        end
    end

    // Second half: rounded interpolation, saturation and sign.
    always_comb begin
        for (int j = 0; j < NEURONS; j++) begin
            rnd[j] = (r_prod[j] + TPROD_W'(1 << (STEP_BITS - 1))) >> STEP_BITS;
            y[j]   = r_sat[j] ? TAB_W'(TANH_ONE) : r_base[j] + TAB_W'(rnd[j]);
            n_y[j] = r_neg[j] ? -t_q14'({1'b0, y[j]}) : t_q14'({1'b0, y[j]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) r_vld1 <= i_vld;
            if (en2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_vld) begin
            r_neg  <= n_neg;
            r_sat  <= n_sat;
            r_base <= n_base;
            r_prod <= n_prod;
        end
        if (en2 && r_vld1) begin
            r_y <= n_y;
        end
    end

endmodule

[rtl/core/mlp_tanh_forward_3_4_4_unit.sv]
`timescale 1ns / 1ps

// Channel   Dir  Payload                                   Format
// i_in      in   feature_dist, feature_angle               Q7.9 and Q2.9 signed, 16 and 11 bits
// o_out     out  out_zero, out_one, out_two, out_three     Q1.14 signed, 16 bits each
//
// One request is taken per cycle unless a stall at the output holds the pipeline; a result
// passes through the four two-stage sections: hidden products and sums, tanh, output
// products and sums, tanh. Reset clears only the stage valid bits.
// Each stage moves on when it is empty or the stage after it moves, so a stall at
// the output fills the bubbles behind it before ready falls at the input.

module mlp_tanh_forward_3_4_4_unit import mtf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mtf_in_if.sink   i_in,
    mtf_out_if.source o_out
);

    logic     hid_vld, hid_rdy;
    t_arg_vec hid_x;
    logic     ht_vld, ht_rdy;
    t_q14_vec ht_y;
    logic     out_vld, out_rdy;
    t_arg_vec out_x;
    t_q14_vec fin_y;

    mtf_hidden u_hidden (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in.valid),
        .o_rdy   (i_in.ready),
        .i_dist  (i_in.feature_dist),
        .i_ang   (i_in.feature_angle),
        .o_vld   (hid_vld),
        .i_rdy   (hid_rdy),
        .o_x     (hid_x)
    );

    mtf_tanh u_tanh_hid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (hid_vld),
        .o_rdy   (hid_rdy),
        .i_x     (hid_x),
        .o_vld   (ht_vld),
        .i_rdy   (ht_rdy),
        .o_y     (ht_y)
    );

    mtf_output u_output (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (ht_vld),
        .o_rdy   (ht_rdy),
        .i_hid   (ht_y),
        .o_vld   (out_vld),
        .i_rdy   (out_rdy),
        .o_x     (out_x)
    );

    mtf_tanh u_tanh_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (out_vld),
        .o_rdy   (out_rdy),
        .i_x     (out_x),
        .o_vld   (o_out.valid),
        .i_rdy   (o_out.ready),
        .o_y     (fin_y)
    );

    assign o_out.out_zero  = fin_y[0];
    assign o_out.out_one   = fin_y[1];
    assign o_out.out_two   = fin_y[2];
    assign o_out.out_three = fin_y[3];

endmodule

[tb/sv/mlp_tanh_forward_3_4_4_unit_tb.sv]
`timescale 1ns / 1ps

module mlp_tanh_forward_3_4_4_unit_tb;
    import mtf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;
    localparam int SETTLE      = 24;
    localparam int SAT_ARG     = 20480;
    localparam int Q14_ONE     = 16384;

    // tanh at steps of 0.25 in Q1.14, with the point at 5.0 forced to one.
    localparam int TANH_PTS [21] = '{
        0, 4013, 7571, 10406, 12478, 13898, 14830, 15423, 15795, 16024,
        16165, 16251, 16303, 16335, 16354, 16366, 16373, 16377, 16380, 16382,
        16384
    };

    // Rows are bias, distance and angle; columns are hidden neurons.
    localparam int HID_WGT [3][4] = '{
        '{7779, -1954, -2656, -1581},
        '{-1155, 16428, 13227, -11855},
        '{1368, -5741, 5562, -4020}
    };

    // Rows are hidden neurons; columns are output neurons.
    localparam int OUT_WGT [4][4] = '{
        '{4653, 6333, 6633, 7708},
        '{-6336, 5715, 794, 1269},
        '{-3177, 3846, 8545, -4600},
        '{-5061, 3516, 2968, 3999}
    };

    typedef struct packed {
        t_q14 zero;
        t_q14 one;
        t_q14 two;
        t_q14 three;
    } t_nn_outputs;

    logic i_clk;
    logic i_rst_n;

    mtf_in_if  in_if ();
    mtf_out_if out_if ();

    mlp_tanh_forward_3_4_4_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_nn_outputs pending_outputs [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint tanh_q14_of(input longint x);
        longint ax, y, i, f, d;
        ax = (x < 0) ? -x : x;
        if (ax >= SAT_ARG) begin
            y = Q14_ONE;
        end else begin
            i = ax >>> 10;
            f = ax & 1023;
            d = TANH_PTS[i + 1] - TANH_PTS[i];
            y = TANH_PTS[i] + ((d * f + 512) >>> 10);
        end
        return (x < 0) ? -y : y;
    endfunction

    // Arithmetic shifts on signed values floor, which gives rounding half up.
    function automatic t_nn_outputs predict_outputs(input logic signed [DIST_W-1:0] dist_val,
                                                    input logic signed [ANG_W-1:0] ang);
        longint      acc;
        longint      hid [4];
        longint      res [4];
        t_nn_outputs o;
        for (int j = 0; j < 4; j++) begin
            acc = longint'(512) * HID_WGT[0][j] + longint'(dist_val) * HID_WGT[1][j]
                + longint'(ang) * HID_WGT[2][j];
            hid[j] = tanh_q14_of((acc + 256) >>> 9);
        end
        for (int k = 0; k < 4; k++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) begin
                acc += hid[j] * OUT_WGT[j][k];
            end
            res[k] = tanh_q14_of((acc + 8192) >>> 14);
        end
        o.zero  = t_q14'(res[0]);
        o.one   = t_q14'(res[1]);
        o.two   = t_q14'(res[2]);
        o.three = t_q14'(res[3]);
        return o;
    endfunction

    task automatic note_mismatch(input string what, input t_nn_outputs want,
                                 input t_nn_outputs got);
        if (mismatch_count < REPORT_MAX) begin
            $display("mismatch (%s) at cycle %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     what, cycle_count, want.zero, want.one, want.two, want.three,
                     got.zero, got.one, got.two, got.three);
        end
        mismatch_count++;
    endtask

    // Results are checked before the prediction for a request taken at the same edge is
    // queued, so the order of the two is fixed.
    always @(posedge i_clk) begin
        t_nn_outputs got;
        t_nn_outputs want;
        if (i_rst_n) begin
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got = '{out_if.out_zero, out_if.out_one, out_if.out_two, out_if.out_three};
                if (pending_outputs.size() == 0) begin
                    note_mismatch("no request outstanding", '0, got);
                end else begin
                    want = pending_outputs.pop_front();
                    if (got.zero !== want.zero || got.one !== want.one
                            || got.two !== want.two || got.three !== want.three) begin
                        note_mismatch("wrong outputs", want, got);
                    end
                end
            end
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
                pending_outputs.push_back(predict_outputs(in_if.feature_dist,
                                                          in_if.feature_angle));
            end
        end
    end

    always @(posedge i_clk) begin
        out_if.ready <= (int'($urandom_range(0, 99)) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** mlp_tanh_forward_3_4_4_unit: FAILED **");
            $finish;
        end
    end

    // Called just after a rising edge; returns just after the edge that took the request,
    // with valid still high.
    task automatic send_request(input logic signed [DIST_W-1:0] dist_val,
                                input logic signed [ANG_W-1:0] ang);
        while (int'($urandom_range(0, 99)) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.feature_dist  <= dist_val;
        in_if.feature_angle <= ang;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_field_extremes();
        send_request(16'sd0, 11'sd0);
        send_request(16'sd32767, 11'sd0);
        send_request(16'sh8000, 11'sd0);
        send_request(16'sd0, 11'sd512);
        send_request(16'sd0, -11'sd512);
        send_request(16'sd0, 11'sd1023);
        send_request(16'sd0, 11'sh400);
        send_request(16'sd32767, 11'sd1023);
        send_request(16'sh8000, 11'sh400);
        send_request(16'sd32767, 11'sh400);
        send_request(16'sh8000, 11'sd1023);
        send_request(16'sh5555, 11'sh2AA);
        send_request(16'shAAAA, 11'sh555);
    endtask

    // Small features keep most hidden sums below saturation, so interpolation is exercised.
    task automatic test_linear_region();
        send_request(16'sd1, 11'sd1);
        send_request(-16'sd1, -11'sd1);
        send_request(16'sd64, 11'sd0);
        send_request(-16'sd64, 11'sd0);
        send_request(16'sd128, -11'sd256);
        send_request(-16'sd200, 11'sd300);
        send_request(16'sd512, 11'sd512);
        send_request(-16'sd512, -11'sd512);
        send_request(16'sd40, 11'sd511);
    endtask

    task automatic test_random_traffic(input int count);
        int                       pick;
        logic signed [DIST_W-1:0] dist_val;
        logic signed [ANG_W-1:0]  ang;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                dist_val = DIST_W'(int'($urandom_range(0, 3072)) - 1536);
                ang      = ANG_W'(int'($urandom_range(0, 1024)) - 512);
            end else if (pick < 80) begin
                dist_val = DIST_W'(int'($urandom_range(0, 512)) - 256);
                ang      = ANG_W'(int'($urandom_range(0, 1024)) - 512);
            end else begin
                dist_val = DIST_W'($urandom());
                ang      = ANG_W'($urandom());
            end
            send_request(dist_val, ang);
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.feature_dist  = '0;
        in_if.feature_angle = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 12;
        recv_idle_pct = 47;
        test_field_extremes();
        test_linear_region();
        wait_for_drain();
        test_random_traffic(300);
        wait_for_drain();

        send_idle_pct = 47;
        recv_idle_pct = 12;
        test_random_traffic(300);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(300);
        wait_for_drain();

        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && pending_outputs.size() == 0) begin
            $display("** mlp_tanh_forward_3_4_4_unit: PASSED **");
        end else begin
            $display("** mlp_tanh_forward_3_4_4_unit: FAILED **");
        end
        $finish;
    end

endmodule
